// ===== hw/rtl/mpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mpp_pkg: shared types and constants of the masked pattern patcher
// Window depth, register indexes and the emit record between the front end,
// the record queue and the output serialiser.
// ----------------------------------------------------------------------------
package mpp_pkg;

  // window depth in bytes (the configuration registers carry eight bytes)
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = $clog2(MaxPattern);
  localparam int unsigned CntW       = $clog2(MaxPattern + 1);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned TotalW     = 32;

  // record queue depth
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatternBytes   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternMask    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgReplaceBytes   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgReplaceMask    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatternLength  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSkipMatches    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMaxReplacements = 3'd6;

  // bytes released by one request, oldest in entry 0
  typedef struct packed {
    logic [MaxPattern-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                  count;
    logic                             last;
    logic [TotalW-1:0]                total;
  } rec_t;

endpackage

// ===== hw/rtl/mpp_front.sv =====
// ----------------------------------------------------------------------------
// mpp_front: window, masked compare and in-place rewrite
// Takes one request a cycle while the record queue has room, updates the
// window and hands the released bytes to the record queue as one record.
// ----------------------------------------------------------------------------
module mpp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mpp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mpp_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  input  logic [mpp_pkg::ByteW-1:0]          data_byte_i,
  input  logic                               last_i,
  input  logic                               push_ready_i,
  output logic                               push_valid_o,
  output mpp_pkg::rec_t                      push_rec_o
);

  localparam int unsigned N  = mpp_pkg::MaxPattern;
  localparam int unsigned BW = mpp_pkg::ByteW;
  localparam int unsigned CW = mpp_pkg::CntW;
  localparam int unsigned TW = mpp_pkg::TotalW;

  // configuration
  logic [N-1:0][BW-1:0] pat_q, pmask_q, rep_q, rmask_q;
  logic [3:0]           len_cfg_q;
  logic [TW-1:0]        skip_cfg_q, max_cfg_q;

  // stream state
  logic [N-1:0][BW-1:0] win_q, win_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        cool_q, cool_d;
  logic [TW-1:0]        skips_q, skips_d;
  logic [TW-1:0]        total_q, total_d;
  logic                 stop_q, stop_d;
  logic                 in_stream_q, in_stream_d;

  logic                 accept;
  logic [CW-1:0]        len, fill_inc, base, keep, n_out, pos, sum;
  logic [N-1:0][BW-1:0] win_ins, win_new;
  logic                 hit;
  logic [CW-1:0]        cool0;
  logic [TW-1:0]        skips0, total0;
  logic                 stop0;
  logic [BW-1:0]        sel;

  assign accept = in_valid_i & push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q      <= '0;
      pmask_q    <= '1;
      rep_q      <= '0;
      rmask_q    <= '1;
      len_cfg_q  <= 4'd1;
      skip_cfg_q <= '0;
      max_cfg_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpp_pkg::CfgPatternBytes:    pat_q      <= cfg_data_i;
        mpp_pkg::CfgPatternMask:     pmask_q    <= cfg_data_i;
        mpp_pkg::CfgReplaceBytes:    rep_q      <= cfg_data_i;
        mpp_pkg::CfgReplaceMask:     rmask_q    <= cfg_data_i;
        mpp_pkg::CfgPatternLength:   len_cfg_q  <= cfg_data_i[3:0];
        mpp_pkg::CfgSkipMatches:     skip_cfg_q <= cfg_data_i[TW-1:0];
        mpp_pkg::CfgMaxReplacements: max_cfg_q  <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, oversize clamps to the window depth
  always_comb begin
    if (len_cfg_q == 4'd0) begin
      len = CW'(1);
    end else if (32'(len_cfg_q) > N) begin
      len = CW'(N);
    end else begin
      len = CW'(len_cfg_q);
    end
  end

  always_comb begin
    // stream start reloads the per-stream counters
    cool0  = in_stream_q ? cool_q  : '0;
    skips0 = in_stream_q ? skips_q : skip_cfg_q;
    total0 = in_stream_q ? total_q : '0;
    stop0  = in_stream_q ? stop_q  : 1'b0;

    // insert the new byte at the fill position
    win_ins = win_q;
    for (int j = 0; j < N; j++) begin
      if (fill_q == CW'(j)) begin
        win_ins[j] = data_byte_i;
      end
    end
    fill_inc = fill_q + CW'(1);
    base     = fill_inc - len;

    // masked compare of the newest len bytes
    hit = 1'b1;
    for (int i = 0; i < N; i++) begin
      pos = base + CW'(i);
      sel = win_ins[pos[mpp_pkg::PosW-1:0]];
      if (CW'(i) < len && (sel & pmask_q[i]) != pat_q[i]) begin
        hit = 1'b0;
      end
    end

    cool_d  = cool0;
    skips_d = skips0;
    total_d = total0;
    stop_d  = stop0;
    win_new = win_ins;

    if (fill_inc >= len) begin
      if (cool0 != '0) begin
        cool_d = cool0 - CW'(1);
      end else if (!stop0 && hit) begin
        cool_d = len - CW'(1);
        if (skips0 != '0) begin
          skips_d = skips0 - TW'(1);
        end else begin
          for (int j = 0; j < N; j++) begin
            pos = CW'(j) - base;
            if (CW'(j) >= base && CW'(j) < fill_inc) begin
              win_new[j] = (win_ins[j] & ~rmask_q[pos[mpp_pkg::PosW-1:0]])
                         | (rep_q[pos[mpp_pkg::PosW-1:0]] & rmask_q[pos[mpp_pkg::PosW-1:0]]);
            end
          end
          if (total0 != '1) begin
            total_d = total0 + TW'(1);
          end
          if (max_cfg_q != '0 && total_d >= max_cfg_q) begin
            stop_d = 1'b1;
          end
        end
      end
    end

    // release bytes beyond the retained depth, all of them on the last byte
    keep  = last_i ? '0 : (len - CW'(1));
    n_out = (fill_inc > keep) ? (fill_inc - keep) : '0;

    for (int j = 0; j < N; j++) begin
      sum = CW'(j) + n_out;
      win_d[j] = (sum < CW'(N)) ? win_new[sum[mpp_pkg::PosW-1:0]] : '0;
    end
    fill_d      = fill_inc - n_out;
    in_stream_d = !last_i;
    if (last_i) begin
      fill_d = '0;
      cool_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fill_q      <= '0;
      cool_q      <= '0;
      skips_q     <= '0;
      total_q     <= '0;
      stop_q      <= 1'b0;
      in_stream_q <= 1'b0;
    end else if (accept) begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      cool_q      <= cool_d;
      skips_q     <= skips_d;
      total_q     <= total_d;
      stop_q      <= stop_d;
      in_stream_q <= in_stream_d;
    end
  end

  assign push_valid_o     = accept && (n_out != '0);
  assign push_rec_o.bytes = win_new;
  assign push_rec_o.count = n_out;
  assign push_rec_o.last  = last_i;
  assign push_rec_o.total = total_d;

endmodule

// ===== hw/rtl/mpp_queue.sv =====
// ----------------------------------------------------------------------------
// mpp_queue: short record queue between front end and serialiser
// Registered occupancy, so ready on the write side never depends on the
// read side in the same cycle.
// ----------------------------------------------------------------------------
module mpp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  mpp_pkg::rec_t wr_rec_i,
  output logic          wr_ready_o,
  output logic          rd_valid_o,
  output mpp_pkg::rec_t rd_rec_o,
  input  logic          rd_pop_i
);

  localparam int unsigned D  = mpp_pkg::QueueDepth;
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned OW = $clog2(D + 1);

  mpp_pkg::rec_t  mem_q [D];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [OW-1:0]  occ_q, occ_d;
  logic           push, pop;

  assign wr_ready_o = (occ_q != OW'(D));
  assign rd_valid_o = (occ_q != '0);
  assign rd_rec_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_pop_i & rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    occ_d    = occ_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      occ_d = occ_q + OW'(1);
    end else if (pop && !push) begin
      occ_d = occ_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

endmodule

// ===== hw/rtl/mpp_back.sv =====
// ----------------------------------------------------------------------------
// mpp_back: output serialiser
// Walks the head record byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module mpp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  mpp_pkg::rec_t                  head_rec_i,
  output logic                           head_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mpp_pkg::ByteW-1:0]      out_byte_o,
  output logic                           out_last_o,
  output logic [mpp_pkg::TotalW-1:0]     replacements_o
);

  localparam int unsigned PW = mpp_pkg::PosW;
  localparam int unsigned CW = mpp_pkg::CntW;

  logic [PW-1:0]                 idx_q, idx_d;
  logic                          valid_q, valid_d;
  logic [mpp_pkg::ByteW-1:0]     byte_q;
  logic                          last_q;
  logic [mpp_pkg::TotalW-1:0]    total_q;
  logic                          load, final_byte;

  assign load       = head_valid_i && (!valid_q || out_ready_i);
  assign final_byte = ((CW'(idx_q) + CW'(1)) == head_rec_i.count);
  assign head_pop_o = load && final_byte;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = final_byte ? '0 : idx_q + PW'(1);
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= head_rec_i.bytes[idx_q];
      last_q  <= final_byte && head_rec_i.last;
      total_q <= (final_byte && head_rec_i.last) ? head_rec_i.total : '0;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign out_last_o     = last_q;
  assign replacements_o = total_q;

endmodule

// ===== hw/rtl/masked_pattern_patcher.sv =====
// ----------------------------------------------------------------------------
// masked_pattern_patcher: masked byte pattern search and replace
// Streams bytes through a window of up to eight bytes, rewrites masked
// matches in place and reports the replacement count on the final byte.
// ----------------------------------------------------------------------------
//
//   channel  handshake                 payload
//   -------  ------------------------  --------------------------------------
//   in       in_valid_i / in_ready_o   data_byte_i, last_i
//   out      out_valid_o / out_ready_i out_byte_o, out_last_o, replacements_o
//   cfg      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// one input request and one output byte per cycle in steady state; a byte
// leaves pattern_length - 1 requests after it entered, then moves through the
// record queue and on into the output register
// a final byte, or a shortened pattern_length, releases several bytes at once;
// the serialiser sends them one a cycle while out_ready_i holds and the input
// stalls when the two-entry record queue is full
// reset clears all stream state and loads the register reset values
//
module masked_pattern_patcher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [mpp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mpp_pkg::CfgDataW-1:0]       cfg_data_i,
  // input byte stream
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mpp_pkg::ByteW-1:0]          data_byte_i,
  input  logic                               last_i,
  // output byte stream
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mpp_pkg::ByteW-1:0]          out_byte_o,
  output logic                               out_last_o,
  output logic [mpp_pkg::TotalW-1:0]         replacements_o
);

  // front end to queue
  logic          push_valid;
  mpp_pkg::rec_t push_rec;
  logic          push_ready;

  // queue to serialiser
  logic          head_valid;
  mpp_pkg::rec_t head_rec;
  logic          head_pop;

  // the front end only takes a request while the queue has room for its record
  assign in_ready_o = push_ready;

  // window, compare, rewrite and release decision
  mpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_rec_o   (push_rec)
  );

  // decouples the front end from output stalls
  mpp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_rec_i   (push_rec),
    .wr_ready_o (push_ready),
    .rd_valid_o (head_valid),
    .rd_rec_o   (head_rec),
    .rd_pop_i   (head_pop)
  );

  // one byte a cycle into the output register while out_ready_i allows
  mpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_rec_i     (head_rec),
    .head_pop_o     (head_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .replacements_o (replacements_o)
  );

endmodule
